>>> rtl/core/lvgb_pkg.sv
// Shared types, constants and fixed-point helpers for the lateral velocity /
// gyro bias estimator. No dependencies.
`default_nettype none
package lvgb_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int CORD_W       = 36;
    localparam int DIV_W        = 32 + FRAC_BITS;
    localparam int DCNT_W       = $clog2(DIV_W + 1);

    localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
    localparam longint S_MIN       = (ONE_Q + 5000) / 10000;
    localparam longint BIAS_LIM    = (15 * ONE_Q + 50) / 100;
    localparam longint COV_VV_INIT = (ONE_Q + 5) / 10;
    localparam longint COV_BB_INIT = (ONE_Q + 50) / 100;

    localparam logic [2:0] CFG_PN_VY   = 3'd0;
    localparam logic [2:0] CFG_PN_BIAS = 3'd1;
    localparam logic [2:0] CFG_N_PSEU  = 3'd2;
    localparam logic [2:0] CFG_N_GPS   = 3'd3;
    localparam logic [2:0] CFG_LR      = 3'd4;
    localparam logic [2:0] CFG_GAIN    = 3'd5;
    localparam logic [2:0] CFG_FLOOR   = 3'd6;
    localparam logic [2:0] CFG_DT      = 3'd7;

    // atan(2^-i) in Q30
    localparam longint ATAN_Q30 [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
        ST_P8, ST_P9, ST_P10, ST_P11, ST_P12, ST_U0, ST_DIV, ST_U2, ST_U3,
        ST_U4, ST_U5, ST_U6, ST_U7, ST_U8, ST_UNEXT, ST_FIN, ST_CORD, ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] cordic_angle(input int i);
        longint a;
        a = (ATAN_Q30[i] + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        return a[31:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lateral_velocity_gyro_bias_ekf_core.sv
// Two-state Kalman filter for lateral velocity and yaw-gyro bias, built on one
// shared multiplier, a radix-2 divider and a CORDIC loop. Uses lvgb_pkg.
//
// Flow: the prediction states, then per measurement update (the GPS one only
// with gps_fix) two divider runs and the update states, skipped when the
// innovation variance is not above S_MIN, then the CORDIC loop (skipped for
// zero lateral speed) and the output state. One word in flight; a new word is
// taken after the result is loaded. Async active-low reset restores the default
// registers, the state and the initial covariance.
`default_nettype none
module lateral_velocity_gyro_bias_ekf_core
    import lvgb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // lateral_accel, yaw_rate, forward_speed, gps_lateral_speed
    input  wire logic [127:0] s_axis_tdata,
    // gps_fix
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // lateral_speed_est, gyro_bias_est, slip_angle, zero pad
    output logic [71:0]       m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [30:0]  cfg_wdata
);

    state_t st_reg, st_next;

    logic [30:0] cfg_reg [0:7];

    logic signed [31:0] vy_reg, bias_reg, cvv_reg, cvb_reg, cbv_reg, cbb_reg;
    logic signed [31:0] ay_reg, wz_reg, vx_reg, vgps_reg;
    logic               gv_reg, second_reg;
    logic signed [31:0] wzc_reg, vdt_reg, tmp_reg, tmp2_reg;
    logic signed [31:0] meas_reg, innov_reg, k0_reg, k1_reg;
    logic signed [31:0] r_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] op_a_reg, op_b_reg;
    logic [31:0]        dvs_reg;
    logic [32:0]        rem_reg;
    logic [DIV_W-1:0]   num_reg;
    logic               dneg_reg, which_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic signed [CORD_W-1:0] cx_reg, cy_reg;
    logic signed [31:0] z_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               out_valid_reg;
    logic [71:0]        out_data_reg;

    // shared multiplier
    logic signed [63:0] prod;
    logic signed [31:0] fm;
    assign prod = op_a_reg * op_b_reg;
    assign fm   = sat32(prod >>> FRAC_BITS);

    logic signed [31:0] dt_s;
    assign dt_s = {1'b0, cfg_reg[CFG_DT]};

    // input fields
    logic signed [31:0] in_ay, in_wz, in_vx, in_vgps, floor_s, vx_fl;
    assign in_ay   = s_axis_tdata[31:0];
    assign in_wz   = s_axis_tdata[63:32];
    assign in_vx   = s_axis_tdata[95:64];
    assign in_vgps = s_axis_tdata[127:96];
    assign floor_s = {1'b0, cfg_reg[CFG_FLOOR]};
    assign vx_fl   = (in_vx < floor_s) ? floor_s : in_vx;

    logic signed [31:0] wzc_calc, vydot_calc;
    assign wzc_calc   = sat32(64'(wz_reg) - 64'(bias_reg));
    assign vydot_calc = sat32(64'(ay_reg) - 64'(fm));

    // innovation variance
    logic signed [33:0] s_calc;
    assign s_calc = 34'(cvv_reg) + 34'(r_reg);

    // divider step
    logic [32:0] trial;
    logic        trial_ok;
    logic [DIV_W-1:0] q_new;
    logic signed [31:0] k_sat;
    assign trial    = {rem_reg[31:0], num_reg[DIV_W-1]} - {1'b0, dvs_reg};
    assign trial_ok = ({rem_reg[31:0], num_reg[DIV_W-1]} >= {1'b0, dvs_reg});
    assign q_new    = {num_reg[DIV_W-2:0], trial_ok};

    always_comb
    begin
        if (dneg_reg)
            k_sat = (q_new > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                      : -32'(q_new);
        else
            k_sat = (q_new > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(q_new);
    end

    function automatic logic [DIV_W-1:0] div_num(input logic signed [31:0] p);
        logic [31:0] mag;
        mag = p[31] ? 32'(-p) : 32'(p);
        return {mag, {FRAC_BITS{1'b0}}};
    endfunction

    // CORDIC step
    logic signed [CORD_W-1:0] cx_sh, cy_sh;
    logic signed [31:0]       ang;
    assign cx_sh = cx_reg >>> iter_reg;
    assign cy_sh = cy_reg >>> iter_reg;
    assign ang   = cordic_angle(int'(iter_reg));

    logic signed [31:0] bias_cl;
    assign bias_cl = (bias_reg > 32'(BIAS_LIM)) ? 32'(BIAS_LIM) :
                     (bias_reg < -32'(BIAS_LIM)) ? -32'(BIAS_LIM) : bias_reg;

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  if (s_axis_tvalid) st_next = ST_P0;
            ST_P0:    st_next = ST_P1;
            ST_P1:    st_next = ST_P2;
            ST_P2:    st_next = ST_P3;
            ST_P3:    st_next = ST_P4;
            ST_P4:    st_next = ST_P5;
            ST_P5:    st_next = ST_P6;
            ST_P6:    st_next = ST_P7;
            ST_P7:    st_next = ST_P8;
            ST_P8:    st_next = ST_P9;
            ST_P9:    st_next = ST_P10;
            ST_P10:   st_next = ST_P11;
            ST_P11:   st_next = ST_P12;
            ST_P12:   st_next = ST_U0;
            ST_U0:    st_next = (s_calc > 34'(S_MIN)) ? ST_DIV : ST_UNEXT;
            ST_DIV:   if (dcnt_reg == DCNT_W'(DIV_W - 1) && which_reg) st_next = ST_U2;
            ST_U2:    st_next = ST_U3;
            ST_U3:    st_next = ST_U4;
            ST_U4:    st_next = ST_U5;
            ST_U5:    st_next = ST_U6;
            ST_U6:    st_next = ST_U7;
            ST_U7:    st_next = ST_U8;
            ST_U8:    st_next = ST_UNEXT;
            ST_UNEXT: st_next = (!second_reg && gv_reg) ? ST_U0 : ST_FIN;
            ST_FIN:   st_next = (vy_reg == 32'sd0) ? ST_OUT : ST_CORD;
            ST_CORD:  if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) st_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || m_axis_tready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0]    <= 31'd98304;
            cfg_reg[1]    <= 31'd328;
            cfg_reg[2]    <= 31'd52429;
            cfg_reg[3]    <= 31'd1311;
            cfg_reg[4]    <= 31'd52429;
            cfg_reg[5]    <= 31'd273;
            cfg_reg[6]    <= 31'd65536;
            cfg_reg[7]    <= 31'd66;
            vy_reg        <= '0;
            bias_reg      <= '0;
            cvv_reg       <= 32'(COV_VV_INIT);
            cvb_reg       <= '0;
            cbv_reg       <= '0;
            cbb_reg       <= 32'(COV_BB_INIT);
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            which_reg     <= 1'b0;
            dcnt_reg      <= '0;
            iter_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg[cfg_addr] <= cfg_wdata;
            // ST_OUT reloads the output itself
            if (out_valid_reg && m_axis_tready && st_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            case (st_reg)
                ST_IDLE:
                begin
                    ay_reg   <= in_ay;
                    wz_reg   <= in_wz;
                    vx_reg   <= vx_fl;
                    vgps_reg <= in_vgps;
                    gv_reg   <= s_axis_tuser;
                end
                ST_P0:
                begin
                    wzc_reg  <= wzc_calc;
                    op_a_reg <= vx_reg;
                    op_b_reg <= wzc_calc;
                end
                ST_P1:
                begin
                    op_a_reg  <= vydot_calc;
                    op_b_reg  <= dt_s;
                end
                ST_P2:
                begin
                    vy_reg   <= sat32(64'(vy_reg) + 64'(fm));
                    op_a_reg <= vx_reg;
                    op_b_reg <= dt_s;
                end
                ST_P3:
                begin
                    vdt_reg  <= fm;
                    acc_reg  <= 64'(cvv_reg);
                    op_a_reg <= fm;
                    op_b_reg <= sat32(64'(cbv_reg) + 64'(cvb_reg));
                end
                ST_P4:
                begin
                    acc_reg  <= acc_reg + 64'(fm);
                    op_a_reg <= vdt_reg;
                    op_b_reg <= vdt_reg;
                end
                ST_P5:
                begin
                    op_a_reg <= fm;
                    op_b_reg <= cbb_reg;
                end
                ST_P6:
                begin
                    acc_reg  <= acc_reg + 64'(fm);
                    op_a_reg <= {1'b0, cfg_reg[CFG_PN_VY]};
                    op_b_reg <= dt_s;
                end
                ST_P7:
                begin
                    cvv_reg  <= sat32(acc_reg + 64'(fm));
                    op_a_reg <= vdt_reg;
                    op_b_reg <= cbb_reg;
                end
                ST_P8:
                begin
                    cvb_reg  <= sat32(64'(cvb_reg) + 64'(fm));
                    cbv_reg  <= sat32(64'(cbv_reg) + 64'(fm));
                    op_a_reg <= {1'b0, cfg_reg[CFG_PN_BIAS]};
                    op_b_reg <= dt_s;
                end
                ST_P9:
                begin
                    cbb_reg  <= sat32(64'(cbb_reg) + 64'(fm));
                    op_a_reg <= {1'b0, cfg_reg[CFG_LR]};
                    op_b_reg <= wzc_reg;
                end
                ST_P10:
                begin
                    tmp_reg  <= fm;
                    op_a_reg <= {1'b0, cfg_reg[CFG_GAIN]};
                    op_b_reg <= ay_reg;
                end
                ST_P11:
                begin
                    op_a_reg <= fm;
                    op_b_reg <= vx_reg;
                end
                ST_P12:
                begin
                    meas_reg   <= sat32(64'(tmp_reg) - 64'(fm));
                    r_reg      <= {1'b0, cfg_reg[CFG_N_PSEU]};
                    second_reg <= 1'b0;
                end
                ST_U0:
                begin
                    innov_reg <= sat32(64'(meas_reg) - 64'(vy_reg));
                    dvs_reg   <= s_calc[31:0];
                    rem_reg   <= '0;
                    num_reg   <= div_num(cvv_reg);
                    dneg_reg  <= cvv_reg[31];
                    which_reg <= 1'b0;
                    dcnt_reg  <= '0;
                end
                ST_DIV:
                begin
                    rem_reg  <= trial_ok ? trial : {rem_reg[31:0], num_reg[DIV_W-1]};
                    num_reg  <= q_new;
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(DIV_W - 1))
                    begin
                        dcnt_reg <= '0;
                        rem_reg  <= '0;
                        if (!which_reg)
                        begin
                            k0_reg    <= k_sat;
                            num_reg   <= div_num(cbv_reg);
                            dneg_reg  <= cbv_reg[31];
                            which_reg <= 1'b1;
                        end
                        else
                            k1_reg <= k_sat;
                    end
                end
                ST_U2:
                begin
                    tmp_reg  <= cvv_reg;
                    tmp2_reg <= cvb_reg;
                    op_a_reg <= k0_reg;
                    op_b_reg <= innov_reg;
                end
                ST_U3:
                begin
                    vy_reg   <= sat32(64'(vy_reg) + 64'(fm));
                    op_a_reg <= k1_reg;
                    op_b_reg <= innov_reg;
                end
                ST_U4:
                begin
                    bias_reg <= sat32(64'(bias_reg) + 64'(fm));
                    op_a_reg <= k0_reg;
                    op_b_reg <= tmp_reg;
                end
                ST_U5:
                begin
                    cvv_reg  <= sat32(64'(cvv_reg) - 64'(fm));
                    op_a_reg <= k0_reg;
                    op_b_reg <= tmp2_reg;
                end
                ST_U6:
                begin
                    cvb_reg  <= sat32(64'(cvb_reg) - 64'(fm));
                    op_a_reg <= k1_reg;
                    op_b_reg <= tmp_reg;
                end
                ST_U7:
                begin
                    cbv_reg  <= sat32(64'(cbv_reg) - 64'(fm));
                    op_a_reg <= k1_reg;
                    op_b_reg <= tmp2_reg;
                end
                ST_U8:
                    cbb_reg <= sat32(64'(cbb_reg) - 64'(fm));
                ST_UNEXT:
                begin
                    if (!second_reg && gv_reg)
                    begin
                        meas_reg   <= vgps_reg;
                        r_reg      <= {1'b0, cfg_reg[CFG_N_GPS]};
                        second_reg <= 1'b1;
                    end
                end
                ST_FIN:
                begin
                    bias_reg <= bias_cl;
                    cx_reg   <= CORD_W'(vx_reg);
                    cy_reg   <= CORD_W'(vy_reg);
                    z_reg    <= '0;
                    iter_reg <= '0;
                end
                ST_CORD:
                begin
                    // rotate toward the x axis, sign of y picks the direction
                    if (!cy_reg[CORD_W-1])
                    begin
                        cx_reg <= cx_reg + cy_sh;
                        cy_reg <= cy_reg - cx_sh;
                        z_reg  <= z_reg + ang;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - cy_sh;
                        cy_reg <= cy_reg + cx_sh;
                        z_reg  <= z_reg - ang;
                    end
                    iter_reg <= iter_reg + ITER_W'(1);
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'd0, z_reg[18:0], bias_reg[14:0], vy_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[46:32]) <= 15'sd9830 &&
                           $signed(m_axis_tdata[46:32]) >= -15'sd9830))
        else $error("bias estimate left its clamp range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[31:0] == 32'd0) |-> m_axis_tdata[65:47] == 19'd0)
        else $error("nonzero slip angle with zero lateral speed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIV) |-> (dcnt_reg < DCNT_W'(DIV_W)))
        else $error("divider step count overran");

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OUT && !out_valid_reg) |=> out_valid_reg)
        else $error("finished word not presented");

endmodule
`default_nettype wire
